### design/aosl_pkg.sv
package aosl_pkg;

  localparam int MaxDepth = 8;
  localparam int DepthW = $clog2(MaxDepth + 1);
  localparam int IdxW = $clog2(MaxDepth);
  localparam int MaxKey = 16;

  localparam logic [1:0] CfgKeyLength = 2'd0;
  localparam logic [1:0] CfgKeyHead = 2'd1;
  localparam logic [1:0] CfgKeyTail = 2'd2;
  localparam logic [1:0] CfgCapacity = 2'd3;

  localparam logic [1:0] StFound = 2'd0;
  localparam logic [1:0] StAbsent = 2'd1;
  localparam logic [1:0] StMalformed = 2'd2;
  localparam logic [1:0] StTooDeep = 2'd3;

  localparam logic [7:0] MkNumber = 8'h00;
  localparam logic [7:0] MkBool = 8'h01;
  localparam logic [7:0] MkString = 8'h02;
  localparam logic [7:0] MkObject = 8'h03;
  localparam logic [7:0] MkNull = 8'h05;
  localparam logic [7:0] MkUndef = 8'h06;
  localparam logic [7:0] MkEcma = 8'h08;
  localparam logic [7:0] MkObjEnd = 8'h09;
  localparam logic [7:0] MkStrict = 8'h0A;
  localparam logic [7:0] MkDate = 8'h0B;
  localparam logic [7:0] MkLong = 8'h0C;

  typedef enum logic [4:0] {
    PH_MARK, PH_TKL, PH_TKEY, PH_TEND, PH_FMARK, PH_FLEN, PH_FCOPY,
    PH_VMARK, PH_SKIP, PH_SLEN, PH_LLEN, PH_ACNT, PH_ECMA, PH_PKL,
    PH_PKEY, PH_PEND, PH_DONE, PH_POP, PH_OUT
  } phase_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       clear;       // new message
    logic       load_cnt;    // countdown <= value picked by cnt_sel
    logic [2:0] cnt_sel;     // 0:2 1:4 2:8 3:1 4:10 5:gather16 6:gather32
    logic       dec_cnt;
    logic       gather;
    logic       key_start;
    logic       key_step;
    logic       push;
    logic       push_arr;
    logic       pop;
    logic       top_write;   // write decremented count to top frame
    logic       emit_byte;
  } cmd_t;

  typedef struct packed {
    logic        cnt_one;      // countdown equals one
    logic        gat16_zero;   // gathered value with this byte, low 16 bits zero
    logic        gat32_zero;
    logic        key_eq;       // key still equal after this byte
    logic        klen_match;
    logic        depth_zero;
    logic        depth_full;
    logic        top_arr;
    logic        top_last;     // top array count is one
    logic        under_limit;
  } stat_t;

endpackage

### design/aosl_ctrl.sv
module aosl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_v,
  input  logic [7:0]         byte_d,
  input  logic               eob,
  input  logic               out_ready,
  input  aosl_pkg::stat_t    st,
  output aosl_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               res_v,
  output logic               res_kind,
  output logic [1:0]         res_status,
  output logic               res_last
);

  aosl_pkg::phase_t phase_r, phase_nxt;
  aosl_pkg::phase_t after_r, after_nxt;
  logic             eob_r, eob_nxt;
  logic             answered_r, answered_nxt;
  logic [1:0]       stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= aosl_pkg::PH_MARK;
      after_r <= aosl_pkg::PH_MARK;
      eob_r <= 1'b0;
      answered_r <= 1'b0;
      stat_r <= aosl_pkg::StFound;
    end else begin
      phase_r <= phase_nxt;
      after_r <= after_nxt;
      eob_r <= eob_nxt;
      answered_r <= answered_nxt;
      stat_r <= stat_nxt;
    end
  end

  // Input waits while frames pop and while the status beat goes out.
  assign busy = (phase_r == aosl_pkg::PH_POP) || (phase_r == aosl_pkg::PH_OUT);

  always_comb begin
    logic       fin;
    logic [1:0] fst;
    logic       vdone;
    logic       eff;
    fin = 1'b0;
    fst = aosl_pkg::StFound;
    vdone = 1'b0;
    phase_nxt = phase_r;
    after_nxt = after_r;
    eob_nxt = eob_r;
    answered_nxt = answered_r;
    stat_nxt = stat_r;
    cmd = '0;
    res_v = 1'b0;
    res_kind = 1'b0;
    res_status = aosl_pkg::StFound;
    res_last = 1'b0;
    eff = byte_v && !answered_r;
    if (phase_r == aosl_pkg::PH_POP) begin
      // Walk up finished array frames, one per cycle.
      vdone = 1'b1;
    end else if (eff) begin
      case (phase_r)
        aosl_pkg::PH_MARK: begin
          if (byte_d == aosl_pkg::MkObject) begin
            phase_nxt = aosl_pkg::PH_TKL;
            cmd.load_cnt = 1'b1;
            cmd.cnt_sel = 3'd0;
          end else begin
            fin = 1'b1; fst = aosl_pkg::StMalformed;
          end
        end
        aosl_pkg::PH_TKL, aosl_pkg::PH_PKL: begin
          cmd.gather = 1'b1;
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one) begin
            if (st.gat16_zero) begin
              phase_nxt = (phase_r == aosl_pkg::PH_TKL) ? aosl_pkg::PH_TEND
                                                        : aosl_pkg::PH_PEND;
            end else begin
              cmd.load_cnt = 1'b1;
              cmd.cnt_sel = 3'd5;
              cmd.key_start = (phase_r == aosl_pkg::PH_TKL);
              phase_nxt = (phase_r == aosl_pkg::PH_TKL) ? aosl_pkg::PH_TKEY
                                                        : aosl_pkg::PH_PKEY;
            end
          end
        end
        aosl_pkg::PH_TEND: begin
          fin = 1'b1;
          fst = (byte_d == aosl_pkg::MkObjEnd) ? aosl_pkg::StAbsent
                                               : aosl_pkg::StMalformed;
        end
        aosl_pkg::PH_TKEY: begin
          cmd.key_step = 1'b1;
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one)
            phase_nxt = st.key_eq ? aosl_pkg::PH_FMARK : aosl_pkg::PH_VMARK;
        end
        aosl_pkg::PH_FMARK: begin
          if (byte_d == aosl_pkg::MkString) begin
            phase_nxt = aosl_pkg::PH_FLEN;
            cmd.load_cnt = 1'b1;
            cmd.cnt_sel = 3'd0;
          end else begin
            fin = 1'b1; fst = aosl_pkg::StMalformed;
          end
        end
        aosl_pkg::PH_FLEN: begin
          cmd.gather = 1'b1;
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one) begin
            if (st.gat16_zero) begin
              fin = 1'b1; fst = aosl_pkg::StFound;
            end else begin
              cmd.load_cnt = 1'b1;
              cmd.cnt_sel = 3'd5;
              phase_nxt = aosl_pkg::PH_FCOPY;
            end
          end
        end
        aosl_pkg::PH_FCOPY: begin
          cmd.dec_cnt = 1'b1;
          if (st.under_limit) begin
            cmd.emit_byte = 1'b1;
            res_v = 1'b1;
          end
          if (st.cnt_one) begin
            fin = 1'b1; fst = aosl_pkg::StFound;
          end
        end
        aosl_pkg::PH_VMARK: begin
          case (byte_d)
            aosl_pkg::MkNumber: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd2; phase_nxt = aosl_pkg::PH_SKIP;
            end
            aosl_pkg::MkBool: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd3; phase_nxt = aosl_pkg::PH_SKIP;
            end
            aosl_pkg::MkDate: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd4; phase_nxt = aosl_pkg::PH_SKIP;
            end
            aosl_pkg::MkString: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd0; phase_nxt = aosl_pkg::PH_SLEN;
            end
            aosl_pkg::MkLong: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd1; phase_nxt = aosl_pkg::PH_LLEN;
            end
            aosl_pkg::MkStrict: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd1; phase_nxt = aosl_pkg::PH_ACNT;
            end
            aosl_pkg::MkEcma: begin
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd1; phase_nxt = aosl_pkg::PH_ECMA;
            end
            aosl_pkg::MkObject: begin
              if (st.depth_full) begin
                fin = 1'b1; fst = aosl_pkg::StTooDeep;
              end else begin
                cmd.push = 1'b1;
                cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd0;
                phase_nxt = aosl_pkg::PH_PKL;
              end
            end
            aosl_pkg::MkNull, aosl_pkg::MkUndef: vdone = 1'b1;
            default: begin
              fin = 1'b1; fst = aosl_pkg::StMalformed;
            end
          endcase
        end
        aosl_pkg::PH_SKIP, aosl_pkg::PH_PKEY: begin
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one) begin
            if (phase_r == aosl_pkg::PH_SKIP) vdone = 1'b1;
            else phase_nxt = aosl_pkg::PH_VMARK;
          end
        end
        aosl_pkg::PH_SLEN, aosl_pkg::PH_LLEN: begin
          cmd.gather = 1'b1;
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one) begin
            if ((phase_r == aosl_pkg::PH_SLEN) ? st.gat16_zero : st.gat32_zero) begin
              vdone = 1'b1;
            end else begin
              cmd.load_cnt = 1'b1;
              cmd.cnt_sel = 3'd6;
              phase_nxt = aosl_pkg::PH_SKIP;
            end
          end
        end
        aosl_pkg::PH_ACNT: begin
          cmd.gather = 1'b1;
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one) begin
            if (st.gat32_zero) begin
              vdone = 1'b1;
            end else if (st.depth_full) begin
              fin = 1'b1; fst = aosl_pkg::StTooDeep;
            end else begin
              cmd.push = 1'b1;
              cmd.push_arr = 1'b1;
              phase_nxt = aosl_pkg::PH_VMARK;
            end
          end
        end
        aosl_pkg::PH_ECMA: begin
          cmd.dec_cnt = 1'b1;
          if (st.cnt_one) begin
            if (st.depth_full) begin
              fin = 1'b1; fst = aosl_pkg::StTooDeep;
            end else begin
              cmd.push = 1'b1;
              cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd0;
              phase_nxt = aosl_pkg::PH_PKL;
            end
          end
        end
        aosl_pkg::PH_PEND: begin
          if (byte_d == aosl_pkg::MkObjEnd && !st.depth_zero) begin
            cmd.pop = 1'b1;
            phase_nxt = aosl_pkg::PH_POP;
          end else begin
            fin = 1'b1; fst = aosl_pkg::StMalformed;
          end
        end
        default: ;
      endcase
    end

    // Value finished: decide where the parse continues.
    if (vdone && !fin) begin
      if (st.depth_zero) begin
        cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd0;
        phase_nxt = aosl_pkg::PH_TKL;
      end else if (st.top_arr) begin
        if (st.top_last) begin
          cmd.pop = 1'b1;
          phase_nxt = aosl_pkg::PH_POP;
        end else begin
          cmd.top_write = 1'b1;
          phase_nxt = aosl_pkg::PH_VMARK;
        end
      end else begin
        cmd.load_cnt = 1'b1; cmd.cnt_sel = 3'd0;
        phase_nxt = aosl_pkg::PH_PKL;
      end
    end

    // A pop stalls input; an end of buffer that came with the byte starting the pop is held.
    if (phase_r == aosl_pkg::PH_POP) begin
      if (eob_r && phase_nxt != aosl_pkg::PH_POP) begin
        fin = !answered_r;
        fst = aosl_pkg::StMalformed;
        eob_nxt = 1'b0;
      end
    end else if (eob && phase_nxt == aosl_pkg::PH_POP) begin
      eob_nxt = 1'b1;
    end

    if (fin) begin
      // Status goes out from PH_OUT, after any final value byte.
      stat_nxt = fst;
      answered_nxt = 1'b1;
      phase_nxt = aosl_pkg::PH_OUT;
      after_nxt = aosl_pkg::PH_DONE;
    end

    // The status waits here until the output register is free.
    if (phase_r == aosl_pkg::PH_OUT && out_ready) begin
      res_v = 1'b1;
      res_kind = 1'b1;
      res_status = stat_r;
      res_last = 1'b1;
      phase_nxt = after_r;
      if (after_r == aosl_pkg::PH_MARK) begin
        answered_nxt = 1'b0;
        cmd.clear = 1'b1;
      end
    end

    if (eob && phase_r != aosl_pkg::PH_POP && phase_nxt != aosl_pkg::PH_POP) begin
      if (!answered_r && !fin) begin
        stat_nxt = aosl_pkg::StMalformed;
        phase_nxt = aosl_pkg::PH_OUT;
      end
      if (phase_nxt == aosl_pkg::PH_OUT) begin
        answered_nxt = 1'b1;
        after_nxt = aosl_pkg::PH_MARK;
      end else begin
        phase_nxt = aosl_pkg::PH_MARK;
        answered_nxt = 1'b0;
        cmd.clear = 1'b1;
      end
    end else if (phase_r == aosl_pkg::PH_POP && eob_r && fin) begin
      after_nxt = aosl_pkg::PH_MARK;
    end
  end

endmodule

### design/aosl_dp.sv
module aosl_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aosl_pkg::cmd_t       cmd,
  input  logic [7:0]           byte_d,
  input  logic [4:0]           key_length,
  input  logic [63:0]          key_head,
  input  logic [63:0]          key_tail,
  input  logic [16:0]          out_capacity,
  output aosl_pkg::stat_t      st,
  output logic [15:0]          copied
);

  logic [31:0]                 cnt_r;
  logic [31:0]                 gat_r;
  logic [3:0]                  kpos_r;
  logic                        keq_r;
  logic [aosl_pkg::DepthW-1:0] depth_r;
  logic [15:0]                 emitted_r;
  logic [32:0]                 stack_r [aosl_pkg::MaxDepth];
  logic [31:0]                 gat_nxt;
  logic [7:0]                  kbyte;
  logic [32:0]                 top;
  logic [aosl_pkg::IdxW-1:0]   top_idx;
  logic [16:0]                 limit;

  assign gat_nxt = {gat_r[23:0], byte_d};
  assign kbyte = kpos_r[3] ? key_tail[8'(63 - 8 * kpos_r[2:0]) -: 8]
                           : key_head[8'(63 - 8 * kpos_r[2:0]) -: 8];
  assign top_idx = aosl_pkg::IdxW'(depth_r - 1'b1);
  assign top = stack_r[top_idx];
  assign limit = (out_capacity == 17'd0) ? 17'd0 : out_capacity - 17'd1;

  assign st.cnt_one = (cnt_r == 32'd1);
  assign st.gat16_zero = (gat_nxt[15:0] == 16'd0);
  assign st.gat32_zero = (gat_nxt == 32'd0);
  assign st.key_eq = keq_r && (kbyte == byte_d);
  assign st.klen_match = keq_r;
  assign st.depth_zero = (depth_r == '0);
  assign st.depth_full = (depth_r == aosl_pkg::DepthW'(aosl_pkg::MaxDepth));
  assign st.top_arr = top[32];
  assign st.top_last = (top[31:0] == 32'd1);
  assign st.under_limit = ({1'b0, emitted_r} < limit);
  assign copied = emitted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      gat_r <= '0;
      kpos_r <= '0;
      keq_r <= 1'b0;
      depth_r <= '0;
      emitted_r <= '0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
      gat_r <= '0;
      kpos_r <= '0;
      keq_r <= 1'b0;
      depth_r <= '0;
      emitted_r <= '0;
    end else begin
      if (cmd.gather) gat_r <= gat_nxt;
      if (cmd.load_cnt) begin
        gat_r <= '0;
        case (cmd.cnt_sel)
          3'd0: cnt_r <= 32'd2;
          3'd1: cnt_r <= 32'd4;
          3'd2: cnt_r <= 32'd8;
          3'd3: cnt_r <= 32'd1;
          3'd4: cnt_r <= 32'd10;
          3'd5: cnt_r <= {16'd0, gat_nxt[15:0]};
          3'd6: cnt_r <= gat_nxt;
          default: cnt_r <= 32'd2;
        endcase
      end else if (cmd.dec_cnt) begin
        cnt_r <= cnt_r - 32'd1;
      end
      if (cmd.key_start) begin
        kpos_r <= '0;
        keq_r <= (key_length >= 5'd1) && (key_length <= 5'(aosl_pkg::MaxKey)) &&
                 (gat_nxt[15:0] == {11'd0, key_length});
      end else if (cmd.key_step) begin
        kpos_r <= kpos_r + 4'd1;
        keq_r <= st.key_eq;
      end
      if (cmd.push) depth_r <= depth_r + 1'b1;
      else if (cmd.pop) depth_r <= depth_r - 1'b1;
      if (cmd.emit_byte) emitted_r <= emitted_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push)
      stack_r[aosl_pkg::IdxW'(depth_r)] <= {cmd.push_arr, cmd.push_arr ? gat_nxt : 32'd0};
    else if (cmd.top_write)
      stack_r[top_idx] <= {1'b1, top[31:0] - 32'd1};
  end

endmodule

### design/amf0_object_string_lookup_unit.sv
// Channel  Dir  tdata                                  tuser / tlast
// in_      in   [7:0] data_byte, [8] byte_present      tlast = end_of_buffer
// out_     out  [7:0] value_byte, [9:8] lookup_status, tuser = item_kind,
//               [25:10] copied_count                   tlast = last
// cfg_     in   index 0..3, data 64 bits
// One input beat per cycle while input is not held off. Closing a nested
// frame pops the stack one frame per cycle, and input is held off while
// frames pop. The status beat follows the deciding beat, and input waits
// until it has gone out. Reset is synchronous, active low; the output
// register stalls input when full.
module amf0_object_string_lookup_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte, byte_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_byte, lookup_status, copied_count
  output logic        out_tuser,  // item_kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]      key_length_r;
  logic [63:0]     key_head_r, key_tail_r;
  logic [16:0]     capacity_r;
  aosl_pkg::cmd_t  cmd, cmd_g;
  aosl_pkg::stat_t st;
  logic            busy, res_v, res_kind, res_last;
  logic [1:0]      res_status;
  logic [15:0]     copied;
  logic            take, step;
  logic            ov_r;
  logic [31:0]     od_r;
  logic            ok_r, ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= 5'd1;
      key_head_r <= '0;
      key_tail_r <= '0;
      capacity_r <= 17'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        aosl_pkg::CfgKeyLength: key_length_r <= cfg_data[4:0];
        aosl_pkg::CfgKeyHead:   key_head_r <= cfg_data;
        aosl_pkg::CfgKeyTail:   key_tail_r <= cfg_data;
        aosl_pkg::CfgCapacity:  capacity_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Advance only when the output register can take any result.
  assign step = !ov_r || out_tready;
  assign in_tready = step && !busy;
  assign take = in_tvalid && in_tready;

  aosl_ctrl u_ctrl (
    .clk, .rst_n,
    .byte_v(take && in_tdata[8]),
    .byte_d(in_tdata[7:0]),
    .eob(take && in_tlast),
    .out_ready(step),
    .st, .cmd,
    .busy,
    .res_v, .res_kind, .res_status, .res_last
  );

  assign cmd_g = cmd;

  aosl_dp u_dp (
    .clk, .rst_n,
    .cmd(cmd_g),
    .byte_d(in_tdata[7:0]),
    .key_length(key_length_r),
    .key_head(key_head_r),
    .key_tail(key_tail_r),
    .out_capacity(capacity_r),
    .st, .copied
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (step) begin
      ov_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_v) begin
      od_r <= res_kind ? {6'd0, copied, res_status, 8'd0} : {24'd0, in_tdata[7:0]};
      ok_r <= res_kind;
      ol_r <= res_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ok_r;
  assign out_tlast = ol_r;

endmodule

### design/aosl_checker.sv
module aosl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tlast))
    else $error("last flag does not match status kind");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:8] == 24'd0)
    else $error("value byte beat carries status bits");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule

bind amf0_object_string_lookup_unit aosl_checker u_aosl_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tuser, .out_tlast
);

### bench/amf0_object_string_lookup_unit_tb.sv
`timescale 1ns / 100ps

module amf0_object_string_lookup_unit_tb;
  import aosl_pkg::*;

  localparam int IdleLimit = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  amf0_object_string_lookup_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  typedef struct {
    logic        kind;
    logic [7:0]  vbyte;
    logic [1:0]  status;
    logic [15:0] count;
    logic        last;
  } lookup_beat_t;

  lookup_beat_t lookup_expected_q[$];
  int           error_count = 0;
  int           items_sent = 0;

  // Lookup predictor: registers and per-message state.
  logic [4:0]  p_key_len;
  logic [63:0] p_key_head;
  logic [63:0] p_key_tail;
  logic [16:0] p_capacity;
  phase_t      p_phase;
  logic [31:0] p_countdown;
  logic [31:0] p_gathered;
  logic [15:0] p_key_pos;
  bit          p_key_equal;
  logic [32:0] p_frames[MaxDepth];
  int unsigned p_depth;
  logic [31:0] p_emitted;
  bit          p_answered;

  // Key as the bench knows it, for building matching messages.
  logic [7:0]  key_bytes[16];
  int          key_len;

  // Message under construction.
  logic [7:0]  msg_q[$];
  int          nest_limit = 4;

  // Idling controls.
  bit          sender_gaps = 1;
  int          burst_left = 0;
  int          rcv_mode = 1;
  int          hold_request = 0;
  int          hold_left = 0;
  logic [15:0] rcv_lfsr = 16'hACE1;
  int          idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void push_result(logic kind, logic [7:0] b, logic [1:0] st,
                                      logic [15:0] cnt, logic last);
    lookup_beat_t r;
    r.kind = kind;
    r.vbyte = b;
    r.status = st;
    r.count = cnt;
    r.last = last;
    lookup_expected_q.push_back(r);
  endfunction

  function automatic void p_new_message();
    p_phase = PH_MARK;
    p_countdown = 0;
    p_gathered = 0;
    p_key_pos = 0;
    p_key_equal = 0;
    p_depth = 0;
    p_emitted = 0;
    p_answered = 0;
  endfunction

  function automatic void p_finish(logic [1:0] st);
    push_result(1'b1, 8'h00, st, p_emitted[15:0], 1'b1);
    p_answered = 1;
    p_phase = PH_DONE;
  endfunction

  function automatic void p_begin_gather(phase_t ph, logic [31:0] n);
    p_phase = ph;
    p_countdown = n;
    p_gathered = 0;
  endfunction

  function automatic bit p_gather(logic [7:0] b);
    p_gathered = {p_gathered[23:0], b};
    p_countdown = p_countdown - 32'd1;
    return p_countdown == 0;
  endfunction

  function automatic void p_value_done();
    logic [32:0] top;
    logic [31:0] c;
    while (1) begin
      if (p_depth == 0) begin
        p_begin_gather(PH_TKL, 2);
        return;
      end
      top = p_frames[p_depth - 1];
      if (top[32]) begin
        c = top[31:0] - 32'd1;
        if (c == 0) begin
          p_depth--;
          continue;
        end
        p_frames[p_depth - 1] = {1'b1, c};
        p_phase = PH_VMARK;
        return;
      end
      p_begin_gather(PH_PKL, 2);
      return;
    end
  endfunction

  function automatic void p_start_skip(logic [31:0] n);
    if (n == 0) begin
      p_value_done();
    end else begin
      p_phase = PH_SKIP;
      p_countdown = n;
    end
  endfunction

  function automatic void p_push_frame(logic [32:0] frame);
    if (p_depth >= MaxDepth) begin
      p_finish(StTooDeep);
      return;
    end
    p_frames[p_depth] = frame;
    p_depth++;
    if (frame[32]) p_phase = PH_VMARK;
    else p_begin_gather(PH_PKL, 2);
  endfunction

  function automatic logic [7:0] p_key_byte(logic [15:0] i);
    if (i < 8) return 8'(p_key_head >> (56 - 8 * i));
    if (i < 16) return 8'(p_key_tail >> (56 - 8 * (i - 8)));
    return 8'h00;
  endfunction

  function automatic void p_value_marker(logic [7:0] b);
    case (b)
      MkNumber: p_start_skip(8);
      MkBool: p_start_skip(1);
      MkString: p_begin_gather(PH_SLEN, 2);
      MkObject: p_push_frame(33'd0);
      MkNull, MkUndef: p_value_done();
      MkEcma: begin
        p_phase = PH_ECMA;
        p_countdown = 4;
      end
      MkStrict: p_begin_gather(PH_ACNT, 4);
      MkDate: p_start_skip(10);
      MkLong: p_begin_gather(PH_LLEN, 4);
      default: p_finish(StMalformed);
    endcase
  endfunction

  function automatic void p_take_byte(logic [7:0] b);
    logic [15:0] klen;
    logic [31:0] limit;
    case (p_phase)
      PH_MARK: begin
        if (b == MkObject) p_begin_gather(PH_TKL, 2);
        else p_finish(StMalformed);
      end
      PH_TKL: begin
        if (p_gather(b)) begin
          klen = p_gathered[15:0];
          if (klen == 0) begin
            p_phase = PH_TEND;
          end else begin
            p_key_pos = 0;
            p_key_equal = p_key_len >= 1 && p_key_len <= MaxKey && klen == p_key_len;
            p_countdown = {16'd0, klen};
            p_phase = PH_TKEY;
          end
        end
      end
      PH_TEND: p_finish(b == MkObjEnd ? StAbsent : StMalformed);
      PH_TKEY: begin
        if (p_key_equal && p_key_byte(p_key_pos) != b) p_key_equal = 0;
        p_key_pos = p_key_pos + 16'd1;
        p_countdown = p_countdown - 32'd1;
        if (p_countdown == 0) p_phase = p_key_equal ? PH_FMARK : PH_VMARK;
      end
      PH_FMARK: begin
        if (b == MkString) p_begin_gather(PH_FLEN, 2);
        else p_finish(StMalformed);
      end
      PH_FLEN: begin
        if (p_gather(b)) begin
          if (p_gathered[15:0] == 0) begin
            p_finish(StFound);
          end else begin
            p_phase = PH_FCOPY;
            p_countdown = {16'd0, p_gathered[15:0]};
          end
        end
      end
      PH_FCOPY: begin
        limit = (p_capacity == 0) ? 32'd0 : {15'd0, p_capacity} - 32'd1;
        if (p_emitted < limit) begin
          push_result(1'b0, b, StFound, 16'd0, 1'b0);
          p_emitted++;
        end
        p_countdown = p_countdown - 32'd1;
        if (p_countdown == 0) p_finish(StFound);
      end
      PH_VMARK: p_value_marker(b);
      PH_SKIP: begin
        p_countdown = p_countdown - 32'd1;
        if (p_countdown == 0) p_value_done();
      end
      PH_SLEN, PH_LLEN: begin
        if (p_gather(b)) p_start_skip(p_gathered);
      end
      PH_ACNT: begin
        if (p_gather(b)) begin
          if (p_gathered == 0) p_value_done();
          else p_push_frame({1'b1, p_gathered});
        end
      end
      PH_ECMA: begin
        p_countdown = p_countdown - 32'd1;
        if (p_countdown == 0) p_push_frame(33'd0);
      end
      PH_PKL: begin
        if (p_gather(b)) begin
          if (p_gathered[15:0] == 0) begin
            p_phase = PH_PEND;
          end else begin
            p_phase = PH_PKEY;
            p_countdown = {16'd0, p_gathered[15:0]};
          end
        end
      end
      PH_PKEY: begin
        p_countdown = p_countdown - 32'd1;
        if (p_countdown == 0) p_phase = PH_VMARK;
      end
      PH_PEND: begin
        if (b == MkObjEnd && p_depth > 0) begin
          p_depth--;
          p_value_done();
        end else begin
          p_finish(StMalformed);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_lookup(logic [7:0] b, logic present, logic eob);
    if (present && !p_answered) p_take_byte(b);
    if (eob) begin
      if (!p_answered) p_finish(StMalformed);
      p_new_message();
    end
  endfunction

  // Sender: one beat, then an optional gap decided after it is taken.
  task automatic send_beat(logic [7:0] b, logic present, logic eob, bit hold_after);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, present, b};
    in_tlast <= eob;
    do @(posedge clk); while (!in_tready);
    predict_lookup(b, present, eob);
    items_sent++;
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0 || hold_after) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(bit hold_after);
    int n;
    bit tail_empty;
    n = msg_q.size();
    tail_empty = (n == 0) || ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      send_beat(msg_q[i], 1'b1, (i == n - 1) && !tail_empty,
                hold_after && (i == n - 1) && !tail_empty);
    end
    if (tail_empty) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold_after);
    msg_q.delete();
  endtask

  // Stops offering, waits until every expected beat is in, then lets stack
  // pops settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (lookup_expected_q.size() != 0) @(posedge clk);
    repeat (MaxDepth + 12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgKeyLength: p_key_len = value[4:0];
      CfgKeyHead: p_key_head = value;
      CfgKeyTail: p_key_tail = value;
      CfgCapacity: p_capacity = value[16:0];
      default: ;
    endcase
  endtask

  // Loads a key; lengths from 0 to 31 outside 1..16 are written as given but match nothing.
  task automatic load_key(int len, bit random_bytes);
    logic [63:0] head;
    logic [63:0] tail;
    for (int i = 0; i < 16; i++) begin
      key_bytes[i] = random_bytes ? 8'($urandom_range(0, 255)) : 8'(8'h61 + i);
      if (i < 8) head[63 - 8 * i -: 8] = key_bytes[i];
      else tail[63 - 8 * (i - 8) -: 8] = key_bytes[i];
    end
    key_len = len;
    write_reg(CfgKeyLength, 64'(len));
    write_reg(CfgKeyHead, head);
    write_reg(CfgKeyTail, tail);
  endtask

  function automatic void put(logic [7:0] b);
    msg_q.push_back(b);
  endfunction

  function automatic void put16(logic [15:0] v);
    put(v[15:8]);
    put(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_match_key();
    int n;
    n = (key_len >= 1 && key_len <= 16) ? key_len : 3;
    put16(16'(n));
    for (int i = 0; i < n; i++) put(key_bytes[i]);
  endfunction

  function automatic void put_string(int n);
    put(MkString);
    put16(16'(n));
    put_random(n);
  endfunction

  function automatic void put_random_key();
    int n;
    n = $urandom_range(1, 6);
    put16(16'(n));
    put_random(n);
  endfunction

  function automatic void put_value(int lvl);
    int n;
    case ($urandom_range(0, 9))
      0: begin put(MkNumber); put_random(8); end
      1: begin put(MkBool); put_random(1); end
      2: put_string($urandom_range(0, 6));
      3: begin
        put(MkObject);
        put_props(lvl);
      end
      4: put(MkNull);
      5: put(MkUndef);
      6: begin
        put(MkEcma);
        put_random(4);
        put_props(lvl);
      end
      7: begin
        n = lvl < nest_limit ? $urandom_range(0, 3) : 0;
        put(MkStrict);
        put32(32'(n));
        for (int i = 0; i < n; i++) put_value(lvl + 1);
      end
      8: begin put(MkDate); put_random(10); end
      default: begin
        n = $urandom_range(0, 5);
        put(MkLong);
        put32(32'(n));
        put_random(n);
      end
    endcase
  endfunction

  function automatic void put_props(int lvl);
    int n;
    n = lvl < nest_limit ? $urandom_range(0, 2) : 0;
    for (int i = 0; i < n; i++) begin
      put_random_key();
      put_value(lvl + 1);
    end
    put16(16'd0);
    put(MkObjEnd);
  endfunction

  // Random message: mostly well formed, some corrupted, cut short or padded.
  function automatic void build_random_message();
    int n;
    int pos;
    put($urandom_range(0, 29) == 0 ? 8'($urandom_range(0, 255)) : MkObject);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        put_match_key();
        if ($urandom_range(0, 4) != 0) put_string($urandom_range(0, 12));
        else put_value(1);
      end else begin
        put_random_key();
        put_value(1);
      end
    end
    put16(16'd0);
    put($urandom_range(0, 19) == 0 ? 8'($urandom_range(0, 255)) : MkObjEnd);
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, msg_q.size() - 1);
      msg_q[pos] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(1, msg_q.size());
      while (msg_q.size() > pos) void'(msg_q.pop_back());
    end
    if ($urandom_range(0, 9) == 0) put_random($urandom_range(1, 4));
  endfunction

  task automatic test_found_and_absent();
    load_key(4, 0);
    put(MkObject); put_random_key(); put(MkNumber); put_random(8);
    put_match_key(); put_string(5); put16(0); put(MkObjEnd);
    send_message(0);
    put(MkObject); put_random_key(); put(MkNull); put16(0); put(MkObjEnd);
    send_message(0);
    put(MkObject); put16(0); put(MkObjEnd);
    send_message(1);
    wait_idle();
  endtask

  task automatic test_malformed_cases();
    put(8'hFF); put16(0); put(MkObjEnd);
    send_message(0);
    put(MkObject); put_random_key(); put(8'h04);
    send_message(0);
    put(MkObject); put_match_key(); put(MkNumber); put_random(8);
    send_message(0);
    put(MkObject); put16(0); put(8'h00);
    send_message(0);
    // Found string cut short: copied bytes come out, then a malformed status.
    put(MkObject); put_match_key(); put(MkString); put16(10); put_random(4);
    send_message(0);
    put(MkObject); put_random_key(); put(MkLong); put32(32'hFFFF_FFFF); put_random(3);
    send_message(0);
    put(MkObject); put_random_key(); put(MkObject); put16(0); put(8'h07);
    send_message(1);
    wait_idle();
  endtask

  task automatic test_nesting_depth();
    put(MkObject);
    put_random_key();
    for (int i = 0; i < MaxDepth; i++) begin
      put(MkStrict);
      put32(1);
    end
    put(MkNull);
    put_match_key(); put_string(2); put16(0); put(MkObjEnd);
    send_message(0);
    put(MkObject);
    put_random_key();
    for (int i = 0; i <= MaxDepth; i++) begin
      put(MkObject);
      put_random_key();
    end
    put(MkNull);
    send_message(0);
    put(MkObject); put_random_key(); put(MkEcma); put_random(4);
    put_random_key(); put(MkStrict); put32(0);
    put16(0); put(MkObjEnd); put_match_key(); put_string(3); put16(0); put(MkObjEnd);
    send_message(1);
    wait_idle();
  endtask

  task automatic test_capacity_limits();
    int caps[5] = '{0, 1, 2, 65536, 131071};
    foreach (caps[i]) begin
      write_reg(CfgCapacity, 64'(caps[i]));
      put(MkObject); put_match_key(); put_string(4); put(8'h55);
      send_message(1);
      wait_idle();
    end
    write_reg(CfgCapacity, 64'd16);
    put(MkObject); put_match_key(); put_string(24); put16(0); put(MkObjEnd);
    send_message(1);
    wait_idle();
    write_reg(CfgCapacity, 64'd256);
  endtask

  task automatic test_key_lengths();
    int lens[4] = '{0, 17, 31, 16};
    foreach (lens[i]) begin
      load_key(lens[i], 1);
      put(MkObject); put16(16'(lens[i]));
      for (int j = 0; j < lens[i]; j++) put(key_bytes[j % 16]);
      put_string(2); put16(0); put(MkObjEnd);
      send_message(0);
      put(MkObject); put_match_key(); put_string(3); put16(0); put(MkObjEnd);
      send_message(1);
      wait_idle();
    end
    load_key(1, 1);
    put(MkObject); put_match_key(); put_string(1); put16(0); put(MkObjEnd);
    send_message(1);
    wait_idle();
  endtask

  // Receiver holds off for a long time while the sender keeps going.
  task automatic test_backpressure();
    load_key(5, 0);
    hold_request = 300;
    for (int i = 0; i < 3; i++) begin
      put(MkObject); put_match_key(); put_string(12); put16(0); put(MkObjEnd);
      send_message(i == 2);
    end
    wait_idle();
  endtask

  task automatic test_random(int key_length_cfg, int capacity, int count);
    int target;
    load_key(key_length_cfg, 1);
    write_reg(CfgCapacity, 64'(capacity));
    target = items_sent + count;
    while (items_sent < target) begin
      nest_limit = $urandom_range(0, 9) == 0 ? MaxDepth + 3 : 4;
      sender_gaps = $urandom_range(0, 3) != 0;
      rcv_mode = $urandom_range(0, 3);
      build_random_message();
      send_message(items_sent >= target);
    end
    wait_idle();
  endtask

  // Result checker, receiver stall pattern and long hold-off.
  always @(posedge clk) begin
    lookup_beat_t e;
    logic [15:0] next_lfsr;
    if (rst_n && out_tvalid && out_tready) begin
      if (lookup_expected_q.size() == 0) begin
        $display("%0t: unexpected beat tuser=%0d tdata=%h tlast=%0d", $time,
                 out_tuser, out_tdata, out_tlast);
        error_count++;
      end else begin
        e = lookup_expected_q.pop_front();
        if (e.kind !== out_tuser || e.vbyte !== out_tdata[7:0] ||
            e.status !== out_tdata[9:8] || e.count !== out_tdata[25:10] ||
            e.last !== out_tlast) begin
          $display("%0t: mismatch expected kind=%0d byte=%h status=%0d count=%0d last=%0d",
                   $time, e.kind, e.vbyte, e.status, e.count, e.last);
          $display("%0t:          actual kind=%0d byte=%h status=%0d count=%0d last=%0d",
                   $time, out_tuser, out_tdata[7:0], out_tdata[9:8], out_tdata[25:10],
                   out_tlast);
          error_count++;
        end
      end
    end
    next_lfsr = {rcv_lfsr[14:0], rcv_lfsr[15] ^ rcv_lfsr[13] ^ rcv_lfsr[12] ^ rcv_lfsr[10]};
    rcv_lfsr <= next_lfsr;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rcv_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= next_lfsr[2:0] != 3'd0;
        2: out_tready <= next_lfsr[0];
        default: out_tready <= next_lfsr[7:4] != 4'd0;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("%0t: no progress, %0d beats outstanding", $time, lookup_expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgKeyLength;
    cfg_data = '0;
    p_key_len = 5'd1;
    p_key_head = '0;
    p_key_tail = '0;
    p_capacity = 17'd256;
    for (int i = 0; i < MaxDepth; i++) p_frames[i] = '0;
    p_new_message();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_found_and_absent();
    test_malformed_cases();
    test_nesting_depth();
    test_capacity_limits();
    test_key_lengths();
    test_backpressure();
    test_random(3, 256, 50);
    test_random(16, 4, 40);
    test_random(1, 0, 30);
    test_random(8, 65536, 40);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
design/aosl_pkg.sv
design/aosl_ctrl.sv
design/aosl_dp.sv
design/amf0_object_string_lookup_unit.sv
design/aosl_checker.sv
bench/amf0_object_string_lookup_unit_tb.sv
